// ----- rtl/bs_pkg.sv -----
// Shared types and constants for the sorted table binary search block.
// No dependencies; imported by bs_step and sorted_table_binary_search.
package bs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_W           = 32;
    localparam int INDEX_W         = 10;
    localparam int LEN_W           = 11;
    localparam int PROBE_W         = 4;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

    // Outcome of one probe compare.
    typedef struct packed {
        logic hit;
        logic less;
    } t_cmp;

endpackage

// ----- rtl/bs_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing; used for the sorted table storage.
module bs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bs_step.sv -----
// Shared probe unit: floor midpoint of the search range, key compare and
// narrowed range for the next probe. Depends on bs_pkg.
module bs_step #(
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic [CW-1:0]              i_lo,
    input  logic [CW-1:0]              i_hi,
    input  logic [AW-1:0]              i_mid,
    input  logic [bs_pkg::KEY_W-1:0]   i_key,
    input  logic [bs_pkg::KEY_W-1:0]   i_rdata,
    output logic [AW-1:0]              o_mid,
    output bs_pkg::t_cmp               o_cmp,
    output logic [CW-1:0]              o_lo_n,
    output logic [CW-1:0]              o_hi_n,
    output logic                       o_more
);
    import bs_pkg::*;

    logic [CW:0] sum;
    logic [CW:0] mid_ext;

    // Range is [lo, hi) with hi exclusive; midpoint of lo and hi-1.
    assign sum     = {1'b0, i_lo} + {1'b0, i_hi} - {{CW{1'b0}}, 1'b1};
    assign mid_ext = sum >> 1;
    assign o_mid   = AW'(mid_ext);

    assign o_cmp.hit  = (i_key == i_rdata);
    assign o_cmp.less = ($signed(i_key) < $signed(i_rdata));

    always_comb begin
        o_lo_n = i_lo;
        o_hi_n = i_hi;
        if (o_cmp.less) begin
            o_hi_n = CW'(i_mid);
        end else if (!o_cmp.hit) begin
            o_lo_n = CW'(i_mid) + CW'(1);
        end
    end

    assign o_more = (o_lo_n < o_hi_n);

endmodule

// ----- rtl/sorted_table_binary_search.sv -----
// Sorted table with iterative binary search.
// Depends on bs_pkg, bs_ram and bs_step.
//
// Input channel (i_in_valid / o_in_ready) carries one transaction: i_kind
// selects a load, which writes i_item_value at i_entry_index, or a search
// for the key i_item_value. Loads at an index past the table depth are
// dropped. The search covers entries 0 to length-1, length taken from the
// register written through i_cfg_we / i_cfg_wdata and clamped to the depth.
// Output channel (o_out_valid / i_out_ready) gives one transaction per
// search: found flag, position (0 on a miss) and probe count.
// Sequencing: a load is written to the RAM as it is accepted. A search
// holds the block from its accept through, per probe, a RAM read state and
// a compare and range update state in the shared probe unit, then a done
// state that places the result in the output register.
// The output register lets a new transaction be accepted while a result
// waits; a finished search holds until the output register is free.
// Reset clears the length register and the control state; table contents
// are undefined until loaded.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = bs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [bs_pkg::INDEX_W-1:0]    i_entry_index,
    input  logic signed [bs_pkg::KEY_W-1:0] i_item_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [bs_pkg::INDEX_W-1:0]    o_position,
    output logic [bs_pkg::PROBE_W-1:0]    o_probes,
    input  logic                          i_cfg_we,
    input  logic [bs_pkg::LEN_W-1:0]      i_cfg_wdata
);
    import bs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    t_state r_state, n_state;

    logic [LEN_W-1:0]   r_len;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hi, n_hi;
    logic [AW-1:0]      r_mid, n_mid;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [PROBE_W-1:0] r_probes, n_probes;
    logic               r_found, n_found;

    logic               r_out_valid, n_out_valid;
    logic               r_out_found;
    logic [INDEX_W-1:0] r_out_pos;
    logic [PROBE_W-1:0] r_out_probes;

    logic               in_fire;
    logic               out_free;
    logic               load_ok;
    logic [CW-1:0]      len_eff;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [KEY_W-1:0]   ram_rdata;

    logic [AW-1:0]      step_mid;
    t_cmp               step_cmp;
    logic [CW-1:0]      step_lo_n;
    logic [CW-1:0]      step_hi_n;
    logic               step_more;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign load_ok  = (32'(i_entry_index) < 32'(TABLE_DEPTH));
    assign len_eff  = (LW'(r_len) > LW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(r_len);

    bs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_item_value),
        .o_rdata (ram_rdata)
    );

    bs_step #(
        .AW (AW),
        .CW (CW)
    ) u_step (
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_mid   (r_mid),
        .i_key   (r_key),
        .i_rdata (ram_rdata),
        .o_mid   (step_mid),
        .o_cmp   (step_cmp),
        .o_lo_n  (step_lo_n),
        .o_hi_n  (step_hi_n),
        .o_more  (step_more)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_kind == KIND_SEARCH) begin
                    n_state = (len_eff == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ: n_state = ST_CMP;
            ST_CMP: begin
                if (step_cmp.hit || !step_more) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        o_in_ready  = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = AW'(i_entry_index);
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_probes    = r_probes;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_fire) begin
                    if (i_kind == KIND_LOAD) begin
                        ram_we = load_ok;
                    end else begin
                        n_lo     = '0;
                        n_hi     = len_eff;
                        n_mid    = '0;
                        n_key    = i_item_value;
                        n_probes = '0;
                        n_found  = 1'b0;
                    end
                end
            end
            ST_READ: begin
                ram_addr = step_mid;
                n_mid    = step_mid;
                if (r_probes != PROBE_MAX) begin
                    n_probes = r_probes + PROBE_W'(1);
                end
            end
            ST_CMP: begin
                n_lo    = step_lo_n;
                n_hi    = step_hi_n;
                n_found = step_cmp.hit;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_key    <= n_key;
        r_probes <= n_probes;
        r_found  <= n_found;
        // Load the result register as the search hands off
        if (r_state == ST_DONE && out_free) begin
            r_out_found  <= r_found;
            r_out_pos    <= r_found ? INDEX_W'(r_mid) : '0;
            r_out_probes <= r_probes;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_position  = r_out_pos;
    assign o_probes    = r_out_probes;

endmodule
